>>> design/arp_pkg.sv
package arp_pkg;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_HOLD    = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_RESET   = 2'd2;
    localparam logic [1:0] REQ_TICK    = 2'd3;

    // Pattern modes.
    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_PLAYED     = 3'd1;
    localparam logic [2:0] MODE_UP         = 3'd2;
    localparam logic [2:0] MODE_DOWN       = 3'd3;
    localparam logic [2:0] MODE_UPDOWN     = 3'd4;
    localparam logic [2:0] MODE_UPDOWN_REP = 3'd5;
    localparam logic [2:0] MODE_RANDOM     = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE       = 2'd0;
    localparam logic [1:0] CFG_STEP_TICKS = 2'd1;
    localparam logic [1:0] CFG_GATE_TICKS = 2'd2;

    // Event kinds.
    localparam logic EV_OFF = 1'b0;
    localparam logic EV_ON  = 1'b1;

    localparam int          CFG_W      = 16;
    localparam int          LFSR_W     = 16;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] TICKS_MAX  = 16'hFFFF;
    localparam logic [15:0] STEP_RESET = 16'd125;
    localparam logic [15:0] GATE_RESET = 16'd75;
    localparam logic [4:0]  DIV_STEPS  = 5'd16;

    // Read address source of the note table.
    typedef enum logic [1:0] {ADDR_I, ADDR_J, ADDR_E} arp_addr_t;

    typedef struct packed {
        arp_addr_t addr_sel;
        logic      latch_in;
        logic      clr_i;
        logic      inc_i;
        logic      clr_j;
        logic      inc_j;
        logic      wr_vel_i;
        logic      append;
        logic      keep_w;
        logic      set_cnt_w;
        logic      clr_table;
        logic      start_play;
        logic      stop_play;
        logic      silence;
        logic      gate_tick;
        logic      step_tick;
        logic      step_prep;
        logic      div_step;
        logic      step_pick;
        logic      set_e_i;
        logic      latch_ni;
        logic      emit_on;
        logic      flush;
    } arp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       i_lt_cnt;
        logic       j_last;
        logic       w_zero;
        logic       match;
        logic       cnt_zero;
        logic       cnt_full;
        logic       mode_off;
        logic       mode_played;
        logic       step_fire;
        logic       div_done;
        logic       rank_hit;
    } arp_status_t;

endpackage

>>> design/arp_ctrl.sv
module arp_ctrl
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  arp_status_t status,
    output arp_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_H_RD, S_H_CMP, S_H_APPEND, S_R_RD, S_R_CMP, S_TICK,
        S_STEP, S_DIV, S_PICK, S_RK_RDI, S_RK_LATI, S_RK_RDJ, S_RK_CMPJ, S_RK_CHK,
        S_RD_E, S_EMIT, S_STOP, S_FIN, S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = ADDR_I;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.req)
                    REQ_HOLD:
                    begin
                        cmd.clr_i  = 1'b1;
                        state_next = S_H_RD;
                    end
                    REQ_RELEASE:
                    begin
                        cmd.clr_i  = 1'b1;
                        state_next = S_R_RD;
                    end
                    REQ_RESET:
                    begin
                        cmd.clr_table = 1'b1;
                        state_next    = S_STOP;
                    end
                    default:
                    begin
                        state_next = S_TICK;
                    end
                endcase
            end
            S_H_RD:
            begin
                state_next = status.i_lt_cnt ? S_H_CMP : S_H_APPEND;
            end
            S_H_CMP:
            begin
                if (status.match)
                begin
                    cmd.wr_vel_i = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = S_H_RD;
                end
            end
            S_H_APPEND:
            begin
                if (status.cnt_full)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.append = 1'b1;
                    if (!status.mode_off && status.cnt_zero)
                    begin
                        cmd.start_play = 1'b1;
                        state_next     = S_STEP;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_R_RD:
            begin
                if (status.i_lt_cnt)
                begin
                    state_next = S_R_CMP;
                end
                else
                begin
                    cmd.set_cnt_w = 1'b1;
                    state_next    = status.w_zero ? S_STOP : S_FIN;
                end
            end
            S_R_CMP:
            begin
                cmd.keep_w = 1'b1;
                cmd.inc_i  = 1'b1;
                state_next = S_R_RD;
            end
            S_TICK:
            begin
                cmd.gate_tick = 1'b1;
                cmd.step_tick = 1'b1;
                state_next    = status.step_fire ? S_STEP : S_FIN;
            end
            S_STEP:
            begin
                cmd.silence = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_STOP;
                end
                else
                begin
                    cmd.step_prep = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_PICK:
            begin
                cmd.step_pick = 1'b1;
                cmd.clr_i     = 1'b1;
                state_next    = status.mode_played ? S_RD_E : S_RK_RDI;
            end
            S_RK_RDI:
            begin
                state_next = S_RK_LATI;
            end
            S_RK_LATI:
            begin
                cmd.latch_ni = 1'b1;
                cmd.clr_j    = 1'b1;
                state_next   = S_RK_RDJ;
            end
            S_RK_RDJ:
            begin
                cmd.addr_sel = ADDR_J;
                state_next   = S_RK_CMPJ;
            end
            S_RK_CMPJ:
            begin
                cmd.inc_j  = 1'b1;
                state_next = status.j_last ? S_RK_CHK : S_RK_RDJ;
            end
            S_RK_CHK:
            begin
                if (status.rank_hit)
                begin
                    cmd.set_e_i = 1'b1;
                    state_next  = S_RD_E;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = S_RK_RDI;
                end
            end
            S_RD_E:
            begin
                cmd.addr_sel = ADDR_E;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_on = 1'b1;
                state_next  = S_FIN;
            end
            S_STOP:
            begin
                cmd.stop_play = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                cmd.flush  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/arp_dp.sv
module arp_dp
    import arp_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        req_type,
    input  logic [6:0]        note_number,
    input  logic [15:0]       velocity,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  arp_cmd_t          cmd,
    output arp_status_t       status,
    output logic              strobe,
    output logic              event_kind,
    output logic [6:0]        out_note,
    output logic [15:0]       out_velocity,
    output logic              last_of_run
);

    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int IW = $clog2(MAX_NOTES);
    localparam int PW = $clog2(2 * MAX_NOTES + 1);

    // Note table, in arrival order.
    logic [6:0]  note_mem [MAX_NOTES];
    logic [15:0] vel_mem  [MAX_NOTES];
    logic [6:0]  q_note_reg;
    logic [15:0] q_vel_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [6:0]    wr_note;
    logic [15:0]   wr_vel;

    logic [1:0]  req_reg;
    logic [6:0]  in_note_reg;
    logic [15:0] in_vel_reg;
    logic [2:0]  mode_reg;
    logic [15:0] step_ticks_reg;
    logic [15:0] gate_ticks_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] pos_reg;
    logic          sounding_valid_reg;
    logic [6:0]    sounding_note_reg;
    logic          running_reg;
    logic [15:0]   sc_reg;
    logic [15:0]   gc_reg;
    logic          ga_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] rank_reg;
    logic [CW-1:0] r_reg;
    logic [6:0]    ni_reg;
    logic [IW-1:0] e_reg;
    logic [LFSR_W-1:0] dvd_reg;
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] dsr_reg;
    logic [4:0]    dcnt_reg;
    logic          pend_v_reg;
    logic          pend_kind_reg;
    logic [6:0]    pend_note_reg;
    logic [15:0]   pend_vel_reg;
    logic          strobe_reg;
    logic          ev_reg;
    logic [6:0]    onote_reg;
    logic [15:0]   ovel_reg;
    logic          last_reg;

    logic [15:0]   gc_inc;
    logic [15:0]   sc_inc;
    logic          gate_fire;
    logic          step_fire;
    logic [LFSR_W-1:0] lfsr_next;
    logic [PW-1:0] cnt_p;
    logic [PW-1:0] len;
    logic [PW-1:0] pick_r;
    logic [PW:0]   div_t;
    logic          silence_req;
    logic          push_v;
    logic          push_kind;
    logic [6:0]    push_note;
    logic [15:0]   push_vel;
    logic [2:0]    cfg_mode;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_J:  rd_addr = j_reg[IW-1:0];
            ADDR_E:  rd_addr = e_reg;
            default: rd_addr = i_reg[IW-1:0];
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg[IW-1:0];
        wr_note = in_note_reg;
        wr_vel  = in_vel_reg;
        if (cmd.wr_vel_i)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[IW-1:0];
        end
        else if (cmd.keep_w && (q_note_reg != in_note_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = w_reg[IW-1:0];
            wr_note = q_note_reg;
            wr_vel  = q_vel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            note_mem[wr_addr] <= wr_note;
            vel_mem[wr_addr]  <= wr_vel;
        end
        q_note_reg <= note_mem[rd_addr];
        q_vel_reg  <= vel_mem[rd_addr];
    end

    assign gc_inc    = (gc_reg == TICKS_MAX) ? gc_reg : gc_reg + 16'd1;
    assign sc_inc    = (sc_reg == TICKS_MAX) ? sc_reg : sc_reg + 16'd1;
    assign gate_fire = ga_reg && (gc_inc >= gate_ticks_reg);
    assign step_fire = running_reg && (sc_inc >= step_ticks_reg);
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign cnt_p     = PW'(cnt_reg);
    assign div_t     = {rem_reg, dvd_reg[LFSR_W-1]};
    assign cfg_mode  = cfg_data[2:0];

    // Pattern length and the rank that the pattern position asks for.
    always_comb
    begin
        case (mode_reg)
            MODE_UPDOWN:     len = (cnt_p > PW'(2)) ? (cnt_p + cnt_p - PW'(2)) : cnt_p;
            MODE_UPDOWN_REP: len = cnt_p + cnt_p;
            default:         len = cnt_p;
        endcase
        case (mode_reg)
            MODE_DOWN:
                pick_r = cnt_p - PW'(1) - rem_reg;
            MODE_UPDOWN:
                pick_r = (rem_reg < cnt_p) ? rem_reg : (cnt_p + cnt_p - PW'(2) - rem_reg);
            MODE_UPDOWN_REP:
                pick_r = (rem_reg < cnt_p) ? rem_reg : (cnt_p + cnt_p - PW'(1) - rem_reg);
            default:
                pick_r = rem_reg;
        endcase
    end

    always_comb
    begin
        silence_req = cmd.silence || cmd.stop_play || (cmd.gate_tick && gate_fire);
        push_v      = 1'b0;
        push_kind   = EV_OFF;
        push_note   = sounding_note_reg;
        push_vel    = '0;
        if (cmd.emit_on)
        begin
            push_v    = 1'b1;
            push_kind = EV_ON;
            push_note = q_note_reg;
            push_vel  = q_vel_reg;
        end
        else if (silence_req && sounding_valid_reg)
        begin
            push_v = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg            <= REQ_HOLD;
            in_note_reg        <= '0;
            in_vel_reg         <= '0;
            mode_reg           <= MODE_OFF;
            step_ticks_reg     <= STEP_RESET;
            gate_ticks_reg     <= GATE_RESET;
            cnt_reg            <= '0;
            pos_reg            <= '0;
            sounding_valid_reg <= 1'b0;
            sounding_note_reg  <= '0;
            running_reg        <= 1'b0;
            sc_reg             <= '0;
            gc_reg             <= '0;
            ga_reg             <= 1'b0;
            lfsr_reg           <= LFSR_SEED;
            i_reg              <= '0;
            j_reg              <= '0;
            w_reg              <= '0;
            rank_reg           <= '0;
            r_reg              <= '0;
            ni_reg             <= '0;
            e_reg              <= '0;
            dvd_reg            <= '0;
            rem_reg            <= '0;
            dsr_reg            <= '0;
            dcnt_reg           <= '0;
            pend_v_reg         <= 1'b0;
            pend_kind_reg      <= EV_OFF;
            pend_note_reg      <= '0;
            pend_vel_reg       <= '0;
            strobe_reg         <= 1'b0;
            ev_reg             <= EV_OFF;
            onote_reg          <= '0;
            ovel_reg           <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:
                    begin
                        if (cfg_mode != mode_reg)
                        begin
                            mode_reg <= cfg_mode;
                            if (cfg_mode == MODE_OFF)
                            begin
                                running_reg <= 1'b0;
                                sc_reg      <= '0;
                            end
                            else
                            begin
                                pos_reg <= '0;
                                if (cnt_reg != '0)
                                begin
                                    running_reg <= 1'b1;
                                    sc_reg      <= TICKS_MAX;
                                end
                            end
                        end
                    end
                    CFG_STEP_TICKS: step_ticks_reg <= cfg_data;
                    CFG_GATE_TICKS: gate_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.latch_in)
            begin
                req_reg     <= req_type;
                in_note_reg <= note_number;
                in_vel_reg  <= velocity;
            end
            if (cmd.clr_i)
            begin
                i_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.inc_i)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.keep_w && (q_note_reg != in_note_reg))
            begin
                w_reg <= w_reg + CW'(1);
            end
            if (cmd.clr_j)
            begin
                j_reg    <= '0;
                rank_reg <= '0;
            end
            if (cmd.inc_j)
            begin
                j_reg <= j_reg + CW'(1);
                if (q_note_reg < ni_reg)
                begin
                    rank_reg <= rank_reg + CW'(1);
                end
            end
            if (cmd.latch_ni)
            begin
                ni_reg <= q_note_reg;
            end
            if (cmd.set_e_i)
            begin
                e_reg <= i_reg[IW-1:0];
            end
            if (cmd.append)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.set_cnt_w)
            begin
                cnt_reg <= w_reg;
            end
            if (cmd.clr_table)
            begin
                cnt_reg <= '0;
                pos_reg <= '0;
            end
            if (cmd.start_play)
            begin
                pos_reg     <= '0;
                running_reg <= 1'b1;
                sc_reg      <= '0;
            end
            if (cmd.gate_tick && ga_reg)
            begin
                if (gate_fire)
                begin
                    ga_reg <= 1'b0;
                    gc_reg <= '0;
                end
                else
                begin
                    gc_reg <= gc_inc;
                end
            end
            if (cmd.step_tick && running_reg)
            begin
                sc_reg <= step_fire ? '0 : sc_inc;
            end
            if (cmd.stop_play)
            begin
                running_reg <= 1'b0;
                sc_reg      <= '0;
                ga_reg      <= 1'b0;
                gc_reg      <= '0;
            end

            // Shared restoring modulo unit: one dividend bit per cycle.
            if (cmd.step_prep)
            begin
                rem_reg  <= '0;
                dcnt_reg <= DIV_STEPS;
                if (mode_reg == MODE_RANDOM)
                begin
                    lfsr_reg <= lfsr_next;
                    dvd_reg  <= lfsr_next;
                    dsr_reg  <= cnt_p;
                end
                else
                begin
                    dvd_reg <= LFSR_W'(pos_reg);
                    dsr_reg <= len;
                end
            end
            if (cmd.div_step)
            begin
                dvd_reg  <= dvd_reg << 1;
                dcnt_reg <= dcnt_reg - 5'd1;
                if (div_t >= {1'b0, dsr_reg})
                begin
                    rem_reg <= PW'(div_t - {1'b0, dsr_reg});
                end
                else
                begin
                    rem_reg <= div_t[PW-1:0];
                end
            end
            if (cmd.step_pick)
            begin
                r_reg <= pick_r[CW-1:0];
                e_reg <= rem_reg[IW-1:0];
                if (mode_reg != MODE_RANDOM)
                begin
                    pos_reg <= rem_reg + PW'(1);
                end
            end

            if (silence_req && sounding_valid_reg)
            begin
                sounding_valid_reg <= 1'b0;
            end
            if (cmd.emit_on)
            begin
                sounding_valid_reg <= 1'b1;
                sounding_note_reg  <= q_note_reg;
                ga_reg             <= 1'b1;
                gc_reg             <= '0;
            end

            // One result is held back so that the final one can be marked.
            if (push_v)
            begin
                pend_v_reg    <= 1'b1;
                pend_kind_reg <= push_kind;
                pend_note_reg <= push_note;
                pend_vel_reg  <= push_vel;
            end
            strobe_reg <= (push_v || cmd.flush) && pend_v_reg;
            if ((push_v || cmd.flush) && pend_v_reg)
            begin
                ev_reg     <= pend_kind_reg;
                onote_reg  <= pend_note_reg;
                ovel_reg   <= pend_vel_reg;
                last_reg   <= cmd.flush;
            end
            if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status             = '0;
        status.req         = req_reg;
        status.i_lt_cnt    = (i_reg < cnt_reg);
        status.j_last      = ((j_reg + CW'(1)) >= cnt_reg);
        status.w_zero      = (w_reg == '0);
        status.match       = (q_note_reg == in_note_reg);
        status.cnt_zero    = (cnt_reg == '0);
        status.cnt_full    = (cnt_reg >= CW'(MAX_NOTES));
        status.mode_off    = (mode_reg == MODE_OFF);
        status.mode_played = (mode_reg == MODE_PLAYED);
        status.step_fire   = step_fire;
        status.div_done    = (dcnt_reg == '0);
        status.rank_hit    = (rank_reg == r_reg);
    end

    assign strobe       = strobe_reg;
    assign event_kind   = ev_reg;
    assign out_note     = onote_reg;
    assign out_velocity = ovel_reg;
    assign last_of_run  = last_reg;

endmodule

>>> design/note_arpeggiator_sequencer.sv
// Arpeggiator: keeps the held notes and steps through them on millisecond ticks.
// Requests enter on start when busy is low: hold, release, reset all or tick,
// with note_number and velocity alongside. Each beat gives zero, one or two
// results on strobe, one cycle each; last_of_run marks the final result of a
// request. The receiver cannot stall, so there is no back-pressure on results.
// Configuration (mode, step_ticks, gate_ticks) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while busy is low, which
// the block does not enforce. It takes effect at once. A hold scans the table
// entry by entry, reading then comparing each. A step runs the modulo unit and
// then, outside played mode, a rank search over the entries tried, each compared
// with every held note one read at a time, since the table has a single read port.
// Results appear before busy falls; the next beat is taken once busy is low.
// Reset clears the table, stops play and reloads the default tick counts and
// the random seed. The table contents are not cleared; the count guards them.
module note_arpeggiator_sequencer
    import arp_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       req_type,
    input  logic [6:0]       note_number,
    input  logic [15:0]      velocity,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             strobe,
    output logic             event_kind,
    output logic [6:0]       out_note,
    output logic [15:0]      out_velocity,
    output logic             last_of_run
);

    // Commands flow from the sequencer to the datapath, status flows back.
    arp_cmd_t    cmd;
    arp_status_t status;

    arp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    arp_dp #(
        .MAX_NOTES (MAX_NOTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .note_number  (note_number),
        .velocity     (velocity),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .strobe       (strobe),
        .event_kind   (event_kind),
        .out_note     (out_note),
        .out_velocity (out_velocity),
        .last_of_run  (last_of_run)
    );

endmodule

>>> design/arp_checker.sv
module arp_checker
    import arp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic        event_kind,
    input logic [15:0] out_velocity,
    input logic        last_of_run
);

    // Results only belong to a request in flight.
    a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("result outside a request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_run) |=> !strobe) else $error("result after the last one");

    a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (event_kind == EV_OFF)) |-> (out_velocity == 16'd0))
        else $error("note off with velocity");

endmodule

bind note_arpeggiator_sequencer arp_checker u_arp_checker (.*);
